// ===== rtl/lslf_pkg.sv =====
// ----------------------------------------------------------------------------
// lslf_pkg - shared types and constants of the line fit core
// Datapath widths of the shared multiply-accumulate unit and the divider,
// fit status codes and the request words that the sequencer hands to them.
// ----------------------------------------------------------------------------
`default_nettype none

package lslf_pkg;

   // point coordinates
   localparam int IN_W      = 16;

   // multiply-accumulate unit: magnitude A times magnitude B, B taken in digits
   localparam int DIGIT_W   = 16;
   localparam int MUL_A_W   = 48;
   localparam int MUL_B_W   = 2 * DIGIT_W;
   localparam int PROD_W    = MUL_A_W + DIGIT_W;
   localparam int ACC_W     = 82;

   // divider: dividend magnitude bits, divisor bits, quotient bits
   localparam int DIV_W     = 88;
   localparam int DIV_NUM_W = DIV_W + 1;
   localparam int DEN_W     = 64;
   localparam int OUT_W     = 48;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam int STATUS_W  = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_DEGEN = 2'd1,
      ST_OVFL  = 2'd2
   } fit_status_type;

   // acc <= init +/- a_mag * b_mag; wide selects two digits of b_mag
   typedef struct packed {
      logic                     start;
      logic                     wide;
      logic                     sub;
      logic [MUL_A_W-1:0]       a_mag;
      logic [MUL_B_W-1:0]       b_mag;
      logic signed [ACC_W-1:0]  init;
   } mac_req_type;

   // quot <= sat(trunc(num / den)), den nonzero
   typedef struct packed {
      logic                        start;
      logic signed [DIV_NUM_W-1:0] num;
      logic [DEN_W-1:0]            den;
   } div_req_type;

endpackage

`default_nettype wire

// ===== rtl/lslf_mac.sv =====
// ----------------------------------------------------------------------------
// lslf_mac - shared multiply-accumulate unit
// Adds or subtracts a magnitude product to a loaded base, one 16-bit digit
// of the B operand per cycle. Result holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_mac import lslf_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mac_req_type             req,
   output logic                         busy,
   output logic signed [ACC_W-1:0]      acc
);

   logic                     busy_ff, busy_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [MUL_A_W-1:0]       a_ff, a_in;
   logic [DIGIT_W-1:0]       bhi_ff, bhi_in;
   logic                     sub_ff, sub_in;

   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  term;
   logic [MUL_A_W-1:0]       a_op;
   logic [DIGIT_W-1:0]       digit;
   logic [PROD_W-1:0]        prod;
   logic                     sub_op;

   always_comb begin
      base   = req.start ? req.init : acc_ff;
      a_op   = req.start ? req.a_mag : a_ff;
      digit  = req.start ? req.b_mag[DIGIT_W-1:0] : bhi_ff;
      sub_op = req.start ? req.sub : sub_ff;
      prod   = a_op * digit;
      // second pass weighs the upper digit
      if (req.start) begin
         term = ACC_W'(prod);
      end else begin
         term = ACC_W'({prod, {DIGIT_W{1'b0}}});
      end

      busy_in = busy_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      bhi_in  = bhi_ff;
      sub_in  = sub_ff;
      if (req.start || busy_ff) begin
         acc_in = sub_op ? (base - term) : (base + term);
      end
      if (req.start) begin
         busy_in = req.wide;
         a_in    = req.a_mag;
         bhi_in  = req.b_mag[MUL_B_W-1:DIGIT_W];
         sub_in  = req.sub;
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      bhi_ff <= bhi_in;
      sub_ff <= sub_in;
   end

   assign busy = busy_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/lslf_div.sv =====
// ----------------------------------------------------------------------------
// lslf_div - iterative signed divider with saturation
// Restoring division, one quotient bit per cycle over the dividend
// magnitude, truncation toward zero, result clamped to 48-bit signed.
// ----------------------------------------------------------------------------
`default_nettype none

module lslf_div import lslf_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire div_req_type             req,
   output logic                         busy,
   output logic signed [OUT_W-1:0]      quot
);

   localparam logic [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   logic                     busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic                     big_ff, big_in;
   logic [DIV_W-1:0]         m_ff, m_in;
   logic [DEN_W-1:0]         r_ff, r_in;
   logic [OUT_W:0]           q_ff, q_in;
   logic [DEN_W-1:0]         d_ff, d_in;
   logic signed [OUT_W-1:0]  quot_ff, quot_in;

   logic [DIV_W-1:0]         num_mag;
   logic [DEN_W:0]           r_sh;
   logic                     ge;
   logic [OUT_W:0]           q_sh;
   logic [OUT_W-1:0]         q_low;
   logic                     sat_pos;
   logic                     sat_neg;

   always_comb begin
      num_mag = req.num[DIV_NUM_W-1] ? DIV_W'(-req.num) : DIV_W'(req.num);
      r_sh    = {r_ff, m_ff[DIV_W-1]};
      ge      = (r_sh >= {1'b0, d_ff});
      q_sh    = {q_ff[OUT_W-1:0], ge};
      q_low   = q_ff[OUT_W-1:0];
      sat_pos = big_ff | q_ff[OUT_W-1];
      sat_neg = big_ff | (q_ff[OUT_W-1] & (|q_ff[OUT_W-2:0]));

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      big_in  = big_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      quot_in = quot_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = req.num[DIV_NUM_W-1];
         big_in  = 1'b0;
         m_in    = num_mag;
         r_in    = '0;
         q_in    = '0;
         d_in    = req.den;
      end else if (busy_ff) begin
         if (cnt_ff == DIV_CNT_W'(DIV_W)) begin
            // all bits done: sign and clamp
            busy_in = 1'b0;
            if (neg_ff) begin
               quot_in = sat_neg ? Q_MIN : OUT_W'(-q_low);
            end else begin
               quot_in = sat_pos ? Q_MAX : q_low;
            end
         end else begin
            cnt_in = DIV_CNT_W'(cnt_ff + 1'b1);
            m_in   = m_ff << 1;
            r_in   = ge ? DEN_W'(r_sh - {1'b0, d_ff}) : r_sh[DEN_W-1:0];
            q_in   = q_sh;
            big_in = big_ff | q_sh[OUT_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      big_ff  <= big_in;
      m_ff    <= m_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
      d_ff    <= d_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/least_squares_line_fit_core.sv =====
// ----------------------------------------------------------------------------
// least_squares_line_fit_core - least-squares straight-line fit
// Accumulates n, Sx, Sy, Sxx, Sxy over a run of points and, on the last
// point, returns slope and intercept in signed fixed point with status.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake            | Word carries
//  --------+-----+----------------------+------------------------------------
//  req     | in  | req_valid/req_stall  | x_value, y_value, is_last
//  rsp     | out | rsp_valid/rsp_stall  | slope, intercept, fit_status
//
//  A point that is accumulated takes two passes through the shared
//  multiply-accumulate unit, for x*x and x*y; a point past capacity takes
//  none. The last point adds the fit: four two-digit MAC passes for D and N,
//  one for the intercept product, and two divisions on the shared divider.
//  Reset is synchronous and clears the sums, count and flags.
//  A finished fit waits in the rsp register; req is taken meanwhile, and the
//  sequencer only holds in its final state if a previous word still stalls.
//
`default_nettype none

module least_squares_line_fit_core import lslf_pkg::*; #(
   parameter int MAX_POINTS = 1024,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // point input
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [IN_W-1:0]    req_x_value,
   input  wire logic signed [IN_W-1:0]    req_y_value,
   input  wire logic                      req_is_last,
   // fit result
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [OUT_W-1:0]        rsp_slope,
   output logic signed [OUT_W-1:0]        rsp_intercept,
   output logic [STATUS_W-1:0]            rsp_fit_status
);

   // accumulator widths follow the capacity
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SX_W  = CNT_W + IN_W - 1;     // |Sx| <= n * 2^15
   localparam int SXX_W = CNT_W + 2*IN_W - 2;   // Sxx <= n * 2^30, unsigned
   localparam int SXY_W = CNT_W + 2*IN_W - 1;   // |Sxy| <= n * 2^30

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_XX   = 11'b00000000010,   // Sxx += x*x
      S_XY   = 11'b00000000100,   // Sxy += x*y
      S_D1   = 11'b00000001000,   // n*Sxx
      S_D2   = 11'b00000010000,   // - Sx*Sx
      S_N1   = 11'b00000100000,   // n*Sxy
      S_N2   = 11'b00001000000,   // - Sx*Sy
      S_DIVS = 11'b00010000000,   // slope = N*2^F / D
      S_ICPT = 11'b00100000000,   // Sy*2^F - slope*Sx
      S_DIVI = 11'b01000000000,   // intercept = ... / n
      S_DONE = 11'b10000000000    // hand result to rsp register
   } state_type;

   // control state
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [SX_W-1:0]   sx_ff, sx_in;
   logic signed [SX_W-1:0]   sy_ff, sy_in;
   logic [SXX_W-1:0]         sxx_ff, sxx_in;
   logic signed [SXY_W-1:0]  sxy_ff, sxy_in;
   logic                     ovf_ff, ovf_in;
   logic                     degen_ff, degen_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [IN_W-1:0]   x_ff, x_in;
   logic signed [IN_W-1:0]   y_ff, y_in;
   logic                     last_ff, last_in;
   logic [DEN_W-1:0]         d_ff, d_in;
   logic signed [OUT_W-1:0]  slope_ff, slope_in;
   logic signed [OUT_W-1:0]  icept_ff, icept_in;
   logic signed [OUT_W-1:0]  rsp_slope_ff, rsp_slope_in;
   logic signed [OUT_W-1:0]  rsp_icept_ff, rsp_icept_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   // shared units
   mac_req_type              mac_req;
   logic                     mac_busy;
   logic signed [ACC_W-1:0]  mac_acc;
   div_req_type              div_req;
   logic                     div_busy;
   logic signed [OUT_W-1:0]  div_quot;

   logic                     req_accept;
   logic                     room;
   logic                     rsp_free;
   logic                     rsp_load;
   logic                     is_mac_state;
   logic                     mac_launch;
   logic                     div_launch;
   fit_status_type           status_now;

   logic [IN_W-1:0]          x_mag_req;
   logic [IN_W-1:0]          x_mag;
   logic [IN_W-1:0]          y_mag;
   logic [SX_W-1:0]          sx_mag;
   logic [SX_W-1:0]          sy_mag;
   logic [SXY_W-1:0]         sxy_mag;
   logic [OUT_W-1:0]         quot_mag;
   logic signed [ACC_W-1:0]  sy_scaled;
   logic signed [DIV_NUM_W-1:0] acc_wide;
   logic signed [DIV_NUM_W-1:0] num_slope;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign room       = (count_ff != CNT_W'(MAX_POINTS));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == S_DONE) && rsp_free;

   // operand magnitudes; most negative values map onto 2^(w-1) unsigned
   always_comb begin
      x_mag_req = req_x_value[IN_W-1] ? IN_W'(-req_x_value) : IN_W'(req_x_value);
      x_mag     = x_ff[IN_W-1] ? IN_W'(-x_ff) : IN_W'(x_ff);
      y_mag     = y_ff[IN_W-1] ? IN_W'(-y_ff) : IN_W'(y_ff);
      sx_mag    = sx_ff[SX_W-1] ? SX_W'(-sx_ff) : SX_W'(sx_ff);
      sy_mag    = sy_ff[SX_W-1] ? SX_W'(-sy_ff) : SX_W'(sy_ff);
      sxy_mag   = sxy_ff[SXY_W-1] ? SXY_W'(-sxy_ff) : SXY_W'(sxy_ff);
      quot_mag  = div_quot[OUT_W-1] ? OUT_W'(-div_quot) : OUT_W'(div_quot);
      sy_scaled = ACC_W'(sy_ff) <<< FRAC_BITS;
      acc_wide  = DIV_NUM_W'(mac_acc);
      num_slope = acc_wide <<< FRAC_BITS;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (room) begin
                  state_in = S_XX;
               end else if (req_is_last) begin
                  state_in = S_DONE;
               end
            end
         end
         S_XX: begin
            if (!mac_busy) state_in = S_XY;
         end
         S_XY: begin
            if (!mac_busy) state_in = last_ff ? S_D1 : S_IDLE;
         end
         S_D1: begin
            if (!mac_busy) state_in = S_D2;
         end
         S_D2: begin
            // zero denominator: all x equal, or a single point
            if (!mac_busy) state_in = (mac_acc == '0) ? S_DONE : S_N1;
         end
         S_N1: begin
            if (!mac_busy) state_in = S_N2;
         end
         S_N2: begin
            if (!mac_busy) state_in = S_DIVS;
         end
         S_DIVS: begin
            if (!div_busy) state_in = S_ICPT;
         end
         S_ICPT: begin
            if (!mac_busy) state_in = S_DIVI;
         end
         S_DIVI: begin
            if (!div_busy) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Each unit pass is launched on the edge that enters its state, so a
   // pass starts in the same cycle the previous one is consumed.
   always_comb begin
      mac_req       = '0;
      is_mac_state  = 1'b1;
      case (state_in)
         S_XX: begin
            mac_req.a_mag = MUL_A_W'(x_mag_req);
            mac_req.b_mag = MUL_B_W'(x_mag_req);
            mac_req.init  = ACC_W'(sxx_ff);
         end
         S_XY: begin
            mac_req.a_mag = MUL_A_W'(x_mag);
            mac_req.b_mag = MUL_B_W'(y_mag);
            mac_req.sub   = x_ff[IN_W-1] ^ y_ff[IN_W-1];
            mac_req.init  = ACC_W'(sxy_ff);
         end
         S_D1: begin
            mac_req.wide  = 1'b1;
            mac_req.a_mag = MUL_A_W'(sxx_ff);
            mac_req.b_mag = MUL_B_W'(count_ff);
         end
         S_D2: begin
            mac_req.wide  = 1'b1;
            mac_req.sub   = 1'b1;
            mac_req.a_mag = MUL_A_W'(sx_mag);
            mac_req.b_mag = MUL_B_W'(sx_mag);
            mac_req.init  = mac_acc;
         end
         S_N1: begin
            mac_req.wide  = 1'b1;
            mac_req.sub   = sxy_ff[SXY_W-1];
            mac_req.a_mag = MUL_A_W'(sxy_mag);
            mac_req.b_mag = MUL_B_W'(count_ff);
         end
         S_N2: begin
            mac_req.wide  = 1'b1;
            mac_req.sub   = !(sx_ff[SX_W-1] ^ sy_ff[SX_W-1]);
            mac_req.a_mag = MUL_A_W'(sx_mag);
            mac_req.b_mag = MUL_B_W'(sy_mag);
            mac_req.init  = mac_acc;
         end
         S_ICPT: begin
            mac_req.wide  = 1'b1;
            mac_req.sub   = !(div_quot[OUT_W-1] ^ sx_ff[SX_W-1]);
            mac_req.a_mag = quot_mag;
            mac_req.b_mag = MUL_B_W'(sx_mag);
            mac_req.init  = sy_scaled;
         end
         default: begin
            is_mac_state = 1'b0;
         end
      endcase
      mac_launch    = is_mac_state && (state_in != state_ff);
      mac_req.start = mac_launch;

      div_launch    = ((state_in == S_DIVS) || (state_in == S_DIVI)) &&
                      (state_in != state_ff);
      div_req.start = div_launch;
      div_req.num   = (state_in == S_DIVS) ? num_slope : acc_wide;
      div_req.den   = (state_in == S_DIVS) ? d_ff : DEN_W'(count_ff);
   end

   always_comb begin
      if (ovf_ff) begin
         status_now = ST_OVFL;
      end else if (degen_ff) begin
         status_now = ST_DEGEN;
      end else begin
         status_now = ST_OK;
      end
   end

   // register updates
   always_comb begin
      count_in      = count_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sxx_in        = sxx_ff;
      sxy_in        = sxy_ff;
      ovf_in        = ovf_ff;
      degen_in      = degen_ff;
      rsp_valid_in  = rsp_valid_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      last_in       = last_ff;
      d_in          = d_ff;
      slope_in      = slope_ff;
      icept_in      = icept_ff;
      rsp_slope_in  = rsp_slope_ff;
      rsp_icept_in  = rsp_icept_ff;
      rsp_status_in = rsp_status_ff;

      if (req_accept) begin
         x_in    = req_x_value;
         y_in    = req_y_value;
         last_in = req_is_last;
         if (room) begin
            count_in = CNT_W'(count_ff + 1'b1);
            sx_in    = SX_W'(sx_ff + SX_W'(req_x_value));
            sy_in    = SX_W'(sy_ff + SX_W'(req_y_value));
         end else begin
            ovf_in = 1'b1;   // capacity reached, point dropped
         end
      end

      if ((state_ff == S_XX) && !mac_busy) sxx_in = mac_acc[SXX_W-1:0];
      if ((state_ff == S_XY) && !mac_busy) sxy_in = mac_acc[SXY_W-1:0];
      if ((state_ff == S_D2) && !mac_busy) begin
         d_in     = mac_acc[DEN_W-1:0];
         degen_in = (mac_acc == '0);
      end
      if ((state_ff == S_DIVS) && !div_busy) slope_in = div_quot;
      if ((state_ff == S_DIVI) && !div_busy) icept_in = div_quot;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_now;
         rsp_slope_in  = (status_now == ST_OK) ? slope_ff : '0;
         rsp_icept_in  = (status_now == ST_OK) ? icept_ff : '0;
         // start a fresh run
         count_in = '0;
         sx_in    = '0;
         sy_in    = '0;
         sxx_in   = '0;
         sxy_in   = '0;
         ovf_in   = 1'b0;
         degen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         ovf_ff       <= 1'b0;
         degen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxx_ff       <= sxx_in;
         sxy_ff       <= sxy_in;
         ovf_ff       <= ovf_in;
         degen_ff     <= degen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      last_ff       <= last_in;
      d_ff          <= d_in;
      slope_ff      <= slope_in;
      icept_ff      <= icept_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_icept_ff  <= rsp_icept_in;
      rsp_status_ff <= rsp_status_in;
   end

   lslf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .busy  (mac_busy),
      .acc   (mac_acc)
   );

   lslf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slope      = rsp_slope_ff;
   assign rsp_intercept  = rsp_icept_ff;
   assign rsp_fit_status = rsp_status_ff;

   // checks
   a_mac_free: assert property (@(posedge clock) disable iff (reset)
      mac_req.start |-> !mac_busy)
      else $error("MAC launched while a pass is in flight");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_busy)
      else $error("divider launched while busy");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CNT_W'(MAX_POINTS)))
      else $error("overflow flagged with room left");

   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (count_ff == '0) && (sx_ff == '0) && (sxx_ff == '0) &&
                   (sxy_ff == '0) && !ovf_ff)
      else $error("sums not cleared after fit");

endmodule

`default_nettype wire

// ===== test/least_squares_line_fit_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least_squares_line_fit_core_tb - regression bench for the line fit core
// Streams runs of points into req under four idling phases, predicts each
// fit word from running sums, and checks every rsp word in order.
// ----------------------------------------------------------------------------

module least_squares_line_fit_core_tb;
   import lslf_pkg::*;

   localparam int CAPACITY      = 1024;       // MAX_POINTS of the instance
   localparam int FRAC          = 16;         // FRAC_BITS of the instance
   localparam int RANDOM_POINTS = 240;        // fewest random points over all phases
   localparam int CYCLE_LIMIT   = 4_000_000;  // watchdog
   localparam int SETTLE_CYCLES = 300;
   localparam int REPORT_MAX    = 10;
   localparam int GAP_MAX       = 40;         // longest sender gap

   typedef struct {
      logic signed [OUT_W-1:0] slope;
      logic signed [OUT_W-1:0] intercept;
      fit_status_type          status;
   } line_fit_type;

   // how coordinates of a run are spread
   typedef enum {SPREAD_FULL, SPREAD_NARROW, NEAR_TOP, NEAR_BOTTOM, SPREAD_FLAT} spread_type;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_type;

   // Running sums of the current run and the queue of fit words still due.
   class fit_ledger;
      int unsigned  n_points = 0;
      longint       sum_x = 0, sum_y = 0, sum_xx = 0, sum_xy = 0;
      bit           overflow = 0;
      line_fit_type fits_due[$];
      int           mismatches = 0;

      static function logic signed [OUT_W-1:0] clamp_q(logic signed [127:0] q);
         if (q > $signed(128'h7FFF_FFFF_FFFF))
            return 48'sh7FFF_FFFF_FFFF;
         if (q < -$signed(128'h8000_0000_0000))
            return 48'sh8000_0000_0000;
         return q[OUT_W-1:0];
      endfunction

      // accepted point; on the last one of a run the fit is predicted
      function void note_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                               logic last);
         longint              xl, yl, n, den, num;
         logic signed [127:0] top, divisor, q;
         line_fit_type        fit;
         xl = x;
         yl = y;
         if (n_points < CAPACITY) begin
            n_points++;
            sum_x  += xl;
            sum_y  += yl;
            sum_xx += xl * xl;
            sum_xy += xl * yl;
         end else begin
            overflow = 1'b1;
         end
         if (!last)
            return;

         fit.slope     = '0;
         fit.intercept = '0;
         fit.status    = ST_OK;
         n   = n_points;
         den = n * sum_xx - sum_x * sum_x;
         num = n * sum_xy - sum_x * sum_y;
         if (overflow) begin
            fit.status = ST_OVFL;
         end else if (den == 0) begin
            fit.status = ST_DEGEN;
         end else begin
            // slope = N * 2^FRAC / D, truncated toward zero
            top     = num;
            top     = top <<< FRAC;
            divisor = den;
            fit.slope = clamp_q(top / divisor);
            // intercept = (Sy * 2^FRAC - slope * Sx) / n with the clamped slope
            top     = sum_y;
            top     = top <<< FRAC;
            q       = fit.slope;
            divisor = sum_x;
            top     = top - q * divisor;
            divisor = n;
            fit.intercept = clamp_q(top / divisor);
         end
         fits_due.push_back(fit);

         n_points = 0;
         sum_x    = 0;
         sum_y    = 0;
         sum_xx   = 0;
         sum_xy   = 0;
         overflow = 1'b0;
      endfunction

      function void check_fit(logic signed [OUT_W-1:0] slope,
                              logic signed [OUT_W-1:0] intercept,
                              logic [STATUS_W-1:0] status);
         line_fit_type want;
         if (fits_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("fit word with none due: slope %0d intercept %0d status %0d",
                        slope, intercept, status);
            return;
         end
         want = fits_due.pop_front();
         if (slope !== want.slope || intercept !== want.intercept ||
             status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display({"fit mismatch: expected slope %0d intercept %0d status %0d,",
                         " got slope %0d intercept %0d status %0d"},
                        want.slope, want.intercept, want.status,
                        slope, intercept, status);
         end
      endfunction

      function int pending();
         return fits_due.size();
      endfunction
   endclass

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   logic signed [IN_W-1:0]  req_x_value = '0;
   logic signed [IN_W-1:0]  req_y_value = '0;
   logic                    req_is_last = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   logic signed [OUT_W-1:0] rsp_slope;
   logic signed [OUT_W-1:0] rsp_intercept;
   logic [STATUS_W-1:0]     rsp_fit_status;

   int          send_idle_pct = 0;   // chance in 100 of an idle cycle before a word
   int          stall_pct     = 0;   // chance in 100 of a stall cycle on rsp
   int          points_sent   = 0;
   int unsigned cycle_count   = 0;
   fit_ledger   ledger        = new();

   least_squares_line_fit_core #(
      .MAX_POINTS (CAPACITY),
      .FRAC_BITS  (FRAC)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_value    (req_x_value),
      .req_y_value    (req_y_value),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slope      (rsp_slope),
      .rsp_intercept  (rsp_intercept),
      .rsp_fit_status (rsp_fit_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("least_squares_line_fit_core regression: fail");
         $finish;
      end
   end

   // Both channels are sampled at the edge that completes the handshake.
   // The result is checked before the point of the same edge is noted, so
   // a fit word is always matched against an earlier run.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            ledger.check_fit(rsp_slope, rsp_intercept, rsp_fit_status);
         if (req_valid && !req_stall)
            ledger.note_point(req_x_value, req_y_value, req_is_last);
      end
   end

   // One point word: optional idle gap, then hold it until taken.
   task automatic send_point(input logic signed [IN_W-1:0] x,
                             input logic signed [IN_W-1:0] y, input logic last);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct && gap < GAP_MAX)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_value <= x;
      req_y_value <= y;
      req_is_last <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      points_sent++;
   endtask

   // Sender goes quiet until every fit word due has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0)
         @(posedge clock);
   endtask

   task automatic set_idling(idle_type mode);
      send_idle_pct = (mode == IDLE_SENDER)   ? 61 : (mode == IDLE_BOTH) ? 29 : 0;
      stall_pct     = (mode == IDLE_RECEIVER) ? 61 : (mode == IDLE_BOTH) ? 29 : 0;
   endtask

   function automatic logic signed [IN_W-1:0] pick_coord(spread_type spread);
      int v;
      case (spread)
         SPREAD_NARROW: v = int'($urandom_range(0, 16)) - 8;
         NEAR_TOP:      v = 32767 - int'($urandom_range(0, 3));
         NEAR_BOTTOM:   v = -32768 + int'($urandom_range(0, 3));
         default:       v = $urandom;
      endcase
      return v[IN_W-1:0];
   endfunction

   // A run of len points; a flat x spread keeps every x equal.
   task automatic send_run(int len, spread_type x_spread, spread_type y_spread);
      logic signed [IN_W-1:0] flat_x;
      flat_x = pick_coord(spread_type'($urandom_range(0, 3)));
      for (int i = 0; i < len; i++)
         send_point((x_spread == SPREAD_FLAT) ? flat_x : pick_coord(x_spread),
                    pick_coord(y_spread), i == len - 1);
   endtask

   initial begin
      int phase_goal;
      int len;
      int draw;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed runs, no idling ---
      // lone point at the corner of the range: zero denominator
      send_point(16'sh7FFF, 16'sh8000, 1'b1);
      // full-scale diagonal
      send_point(16'sh8000, 16'sh8000, 1'b0);
      send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
      // steepest falling slope at the top of x: intercept near +2^31
      send_point(16'sh7FFE, 16'sh7FFF, 1'b0);
      send_point(16'sh7FFF, 16'sh8000, 1'b1);
      // steepest falling slope at the bottom of x: intercept near -2^31
      send_point(16'sh8000, 16'sh7FFF, 1'b0);
      send_point(16'sh8001, 16'sh8000, 1'b1);
      // every x equal: zero denominator
      send_point(16'sh8000, 16'sd5, 1'b0);
      send_point(16'sh8000, -16'sd7, 1'b0);
      send_point(16'sh8000, 16'sd0, 1'b1);
      // small negative slope, intercept fraction truncated toward zero
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd1, -16'sd1, 1'b0);
      send_point(16'sd2, -16'sd3, 1'b1);
      // mixed signs in slope and intercept
      send_point(16'sd0, 16'sd5, 1'b0);
      send_point(16'sd3, 16'sd0, 1'b0);
      send_point(16'sd7, 16'sd1, 1'b0);
      send_point(-16'sd1, -16'sd1, 1'b1);
      hold_until_drained();

      // --- random runs under each idling phase ---
      for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
         set_idling(idle_type'(m));
         // sums filled to capacity, then two points past it, the last word
         // among the ignored ones
         if (m == IDLE_BOTH)
            send_run(CAPACITY + 2, SPREAD_FULL, SPREAD_FULL);
         phase_goal = points_sent + RANDOM_POINTS / 4;
         while (points_sent < phase_goal) begin
            draw = $urandom_range(0, 99);
            if (draw < 8)
               len = 1;
            else if (draw < 12)
               len = $urandom_range(40, 150);
            else
               len = $urandom_range(2, 12);
            send_run(len, spread_type'($urandom_range(0, 4)),
                     spread_type'($urandom_range(0, 3)));
         end
         // sender pauses until the phase's fits are all back
         hold_until_drained();
      end

      // nothing more due; give a late stray word time to show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("least_squares_line_fit_core regression: pass");
      else
         $display("least_squares_line_fit_core regression: fail");
      $finish;
   end

endmodule
